/* hdl/ms_pkg.sv */
// Shared types, op and status codes and depth default for the max stack.
package ms_pkg;

  localparam int MS_DEPTH = 16;

  localparam logic [2:0] OP_PUSH    = 3'd0;
  localparam logic [2:0] OP_POP     = 3'd1;
  localparam logic [2:0] OP_TOP     = 3'd2;
  localparam logic [2:0] OP_PEEKMAX = 3'd3;
  localparam logic [2:0] OP_POPMAX  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } out_t;

endpackage

/* hdl/max_stack.sv */
// Top level of the bounded max stack: sequencer, entry memory, output register.
//
//   channel | direction | beat  | handshake
//   in_     | input     | in_t  | in_valid / in_stall (stall driven here)
//   out_    | output    | out_t | out_valid / out_stall (stall driven by sink)
//
// Path of a request from accept to result ready in the output register: push goes
//   straight to done, pop and read top through the read state, read maximum through
//   a scan of every entry, pop maximum through that scan and a shift-down above it;
//   the max scan and the shift-down both run through the single memory read port.
// Reset clears the entry count, the sequencer state and the output valid; entry contents are not cleared.
// A stalled result holds in the output register while the next request is taken.
module max_stack import ms_pkg::*; #(
  parameter int DEPTH = MS_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  in_t  in_beat,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_beat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          res_valid;
  logic          res_ready;
  out_t          res_beat;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  logic          out_valid_r;
  out_t          out_beat_r;

  // Sequencer owns the stack count and walks the entries one per cycle.
  ms_seq #(.DEPTH(DEPTH)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_beat   (in_beat),
    .in_stall  (in_stall),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_beat  (res_beat),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Entry storage, bottom of the stack at address zero.
  ms_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: load when empty or being drained this cycle.
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      // drop the beat once taken
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_beat_r <= res_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

/* hdl/ms_mem.sv */
// Stack entry storage: one write port, one read port with registered data.
module ms_mem import ms_pkg::*; #(
  parameter int DEPTH = MS_DEPTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/ms_seq.sv */
// Request sequencer: push/pop, max scan over the entries with one shared
// signed comparator, and the shift-down pass that closes the gap.
module ms_seq import ms_pkg::*; #(
  parameter int DEPTH = MS_DEPTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  in_t           in_beat,
  output logic          in_stall,
  output logic          res_valid,
  input  logic          res_ready,
  output out_t          res_beat,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [31:0]   mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [31:0]   mem_rdata
);

  localparam int XW = CW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      best_idx_r, best_idx_nxt;
  logic signed [31:0] best_val_r, best_val_nxt;
  logic               popmax_r, popmax_nxt;
  out_t               res_r, res_nxt;

  logic [CW-1:0]      count_m1;
  logic [XW-1:0]      cnt_x, idx1, idx2, bi1;
  logic               take;
  logic signed [31:0] bv;
  logic [AW-1:0]      bi;

  assign count_m1 = count_r - CW'(1);
  assign cnt_x    = XW'(count_r);
  assign idx1     = XW'(idx_r) + XW'(1);
  assign idx2     = XW'(idx_r) + XW'(2);

  // shared compare: topmost wins ties, first entry always taken
  assign take = (idx_r == '0) || ($signed(mem_rdata) >= best_val_r);
  assign bv   = take ? $signed(mem_rdata) : best_val_r;
  assign bi   = take ? idx_r : best_idx_r;
  assign bi1  = XW'(bi) + XW'(1);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    best_idx_nxt = best_idx_r;
    best_val_nxt = best_val_r;
    popmax_nxt   = popmax_r;
    res_nxt      = res_r;
    mem_we       = 1'b0;
    mem_waddr    = idx_r;
    mem_wdata    = in_beat.value;
    mem_raddr    = '0;
    res_valid    = 1'b0;
    case (state_r)
      S_IDLE: begin
        res_nxt = '{result_value: '0, status: ST_OK};
        if (in_valid) begin
          case (in_beat.op)
            OP_PUSH: begin
              state_nxt = S_DONE;
              if (count_r == CW'(DEPTH)) begin
                res_nxt.status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[AW-1:0];
                count_nxt = count_r + CW'(1);
              end
            end
            OP_POP, OP_TOP: begin
              if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                mem_raddr = count_m1[AW-1:0];
                if (in_beat.op == OP_POP) begin
                  count_nxt = count_m1;
                end
                state_nxt = S_RD;
              end
            end
            OP_PEEKMAX, OP_POPMAX: begin
              if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                mem_raddr  = '0;
                idx_nxt    = '0;
                popmax_nxt = (in_beat.op == OP_POPMAX);
                state_nxt  = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_RD: begin
        res_nxt.result_value = $signed(mem_rdata);
        state_nxt            = S_DONE;
      end
      S_SCAN: begin
        best_val_nxt = bv;
        best_idx_nxt = bi;
        if (idx1 < cnt_x) begin
          mem_raddr = idx1[AW-1:0];
          idx_nxt   = idx1[AW-1:0];
        end else begin
          res_nxt.result_value = bv;
          state_nxt            = S_DONE;
          if (popmax_r) begin
            idx_nxt = bi;
            if (bi1 < cnt_x) begin
              mem_raddr = bi1[AW-1:0];
              state_nxt = S_SHIFT;
            end else begin
              count_nxt = count_m1;
            end
          end
        end
      end
      S_SHIFT: begin
        // move the entry above down one slot, fetch the next one
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        idx_nxt   = idx1[AW-1:0];
        if (idx2 < cnt_x) begin
          mem_raddr = idx2[AW-1:0];
        end else begin
          count_nxt = count_m1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    idx_r      <= idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
    popmax_r   <= popmax_nxt;
    res_r      <= res_nxt;
  end

  assign in_stall = (state_r != S_IDLE);
  assign res_beat = res_r;

endmodule

/* hdl/ms_check.sv */
// Port-level assertions for the max stack, bound to the top level.
module ms_check import ms_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_beat
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_beat))
    else $error("result beat changed while stalled");

  // every accepted request leaves the block busy in the cycle after
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted with no busy cycle");

  // status is one of the defined codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_beat.status == ST_OK || out_beat.status == ST_EMPTY ||
                   out_beat.status == ST_FULL))
    else $error("undefined status code");

  // reset empties the output register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind max_stack ms_check u_ms_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_beat  (out_beat)
);

/* tb/tb_top.sv */
// Self-checking testbench for the bounded max stack: directed and random requests.
module tb_top;
  import ms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = MS_DEPTH;

  // Op codes the block must ignore: they still give one result, zero value and ok status.
  localparam logic [2:0] OP_SPARE_LO  = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  // Cycles in which no beat moves on either channel before the run is abandoned.
  // It must exceed the slowest request, a pop maximum, and the long receiver hold.
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT_RESULT = 300;
  localparam int RANDOM_PER_PHASE = 700;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_t in_beat = '0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_beat;

  max_stack #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_beat   (in_beat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Requests waiting to be offered, and the results predicted for accepted requests.
  in_t req_queue[$];
  out_t pending_results[$];

  // Shadow copy of the stack, advanced once per accepted request.
  logic signed [31:0] shadow_mem [DEPTH];
  int shadow_level = 0;

  // Fill level as seen while building stimulus, so sequences can aim at full and empty.
  int gen_level = 0;

  int err_cnt = 0;
  int idle_cycles = 0;

  // Compute the result of one request and advance the shadow stack.
  function automatic out_t stack_result(in_t req);
    out_t r;
    int best;
    int i;
    r.result_value = '0;
    r.status = ST_OK;
    case (req.op)
      OP_PUSH: begin
        if (shadow_level >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_mem[shadow_level] = req.value;
          shadow_level++;
        end
      end
      OP_POP, OP_TOP, OP_PEEKMAX, OP_POPMAX: begin
        if (shadow_level == 0) begin
          r.status = ST_EMPTY;
        end else if (req.op == OP_POP) begin
          shadow_level--;
          r.result_value = shadow_mem[shadow_level];
        end else if (req.op == OP_TOP) begin
          r.result_value = shadow_mem[shadow_level - 1];
        end else begin
          // Greatest value wins; on a tie the entry nearer the top wins.
          best = 0;
          for (i = 1; i < shadow_level; i++) begin
            if (shadow_mem[i] >= shadow_mem[best]) best = i;
          end
          r.result_value = shadow_mem[best];
          if (req.op == OP_POPMAX) begin
            // Close the gap: entries above the removed one drop by one.
            for (i = best; i + 1 < shadow_level; i++) shadow_mem[i] = shadow_mem[i + 1];
            shadow_level--;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Queue one request and track the fill level it leaves behind.
  task automatic add_req(input logic [2:0] op, input logic signed [31:0] value);
    in_t req;
    req.op = op;
    req.value = value;
    req_queue.push_back(req);
    if (op == OP_PUSH && gen_level < DEPTH) gen_level++;
    else if ((op == OP_POP || op == OP_POPMAX) && gen_level > 0) gen_level--;
  endtask

  // Mix extremes, a narrow band that makes ties likely, and full-range values.
  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      1, 2: return $signed($urandom_range(0, 7)) - 32'sd4;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] rand_read_op();
    case ($urandom_range(0, 3))
      0: return OP_POP;
      1: return OP_TOP;
      2: return OP_PEEKMAX;
      default: return OP_POPMAX;
    endcase
  endfunction

  // Build about n counted requests as runs: fill to full, drain to empty, mixed, noise.
  task automatic build_random(input int n);
    int made;
    int k;
    made = 0;
    while (made < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          while (gen_level < DEPTH) begin
            if ($urandom_range(0, 4) == 0) add_req(($urandom_range(0, 1) != 0) ? OP_TOP : OP_PEEKMAX,
                                                   $urandom);
            else add_req(OP_PUSH, rand_value());
            made++;
          end
          k = $urandom_range(1, 2);
          repeat (k) begin
            add_req(OP_PUSH, rand_value());
            made++;
          end
        end
        3, 4: begin
          while (gen_level > 0) begin
            add_req(($urandom_range(0, 2) == 0) ? OP_POP : OP_POPMAX, $urandom);
            made++;
          end
          add_req(rand_read_op(), $urandom);
          made++;
        end
        5, 6, 7, 8: begin
          k = $urandom_range(4, 20);
          repeat (k) begin
            if ($urandom_range(0, 9) < 4) add_req(OP_PUSH, rand_value());
            else add_req(rand_read_op(), $urandom);
            made++;
          end
        end
        default: begin
          // Unused codes are ignored by the block; do not count them.
          k = $urandom_range(1, 3);
          repeat (k) add_req(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), $urandom);
        end
      endcase
    end
  endtask

  // Block until the sender is drained and every predicted result has come back.
  task automatic wait_drained();
    while (req_queue.size() != 0 || in_valid || pending_results.size() != 0) @(negedge clk);
  endtask

  // Driver: offer beats in bursts with random gaps; hold a beat until it is accepted.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_beat <= '0;
    end else begin
      if (in_valid && !in_stall) pending_results.push_back(stack_result(in_beat));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_queue.size() != 0) begin
          in_beat <= req_queue[0];
          req_queue.delete(0);
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // End of burst: pick the next burst length and the gap before it.
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall on a pattern that changes mode now and then, with one long hold.
  int seen_results = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int pattern_cnt = 0;
  int stall_mode = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) seen_results++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && seen_results == HOLD_AT_RESULT) begin
        // Hold off long enough that the block backs up and stalls its input.
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        pattern_cnt++;
        if (pattern_cnt % 97 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) != 0);
          2: out_stall <= (pattern_cnt % 4 == 0);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // Monitor: compare every accepted result beat with the oldest prediction.
  out_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t: result beat with none expected, actual value %h status %0d",
                 $realtime, out_beat.result_value, out_beat.status);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_beat.result_value !== want.result_value) begin
          err_cnt++;
          $display("%0t: result_value mismatch, expected %h actual %h",
                   $realtime, want.result_value, out_beat.result_value);
        end
        if (out_beat.status !== want.status) begin
          err_cnt++;
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $realtime, want.status, out_beat.status);
        end
      end
    end
  end

  // Count cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int i;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reads and pops on an empty stack.
    add_req(OP_POP, 32'sd5);
    add_req(OP_TOP, VAL_MAX);
    add_req(OP_PEEKMAX, VAL_MIN);
    add_req(OP_POPMAX, -32'sd1);
    // Extremes, with a tie on the maximum: pop maximum must take the upper copy.
    add_req(OP_PUSH, VAL_MIN);
    add_req(OP_PUSH, VAL_MAX);
    add_req(OP_PUSH, -32'sd1);
    add_req(OP_PUSH, VAL_MAX);
    add_req(OP_TOP, 32'sd0);
    add_req(OP_POPMAX, 32'sd0);
    add_req(OP_PEEKMAX, 32'sd0);
    // Unused codes leave the stack alone.
    add_req(OP_SPARE_LO, VAL_MAX);
    add_req(OP_SPARE_MID, 32'sd0);
    add_req(OP_SPARE_HI, -32'sd1);
    // Fill to full, then push once more.
    for (i = 0; gen_level < DEPTH; i++) add_req(OP_PUSH, (i % 2 == 0) ? 32'sd0 : VAL_MIN);
    add_req(OP_PUSH, VAL_MAX);

    // Pause the sender until every result is back, then start the random runs.
    wait_drained();
    build_random(RANDOM_PER_PHASE);
    wait_drained();
    build_random(RANDOM_PER_PHASE);
    wait_drained();

    // Let any stray beat surface before the verdict.
    repeat (2 * DEPTH + 8) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
